// File: src/assert_macros.svh
// Assertion macros used by the checker file of the 1-Wire bus master.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/owm_pkg.sv
// Shared types, codes and constants of the 1-Wire bus master.
// No dependencies; used by every module of the block but owm_fifo.
package owm_pkg;

  localparam int TIMER_WIDTH_DEF = 10;
  localparam int CFG_W           = 10;
  localparam int NUM_REGS        = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int IN_Q_DEPTH      = 4;
  localparam int OUT_Q_DEPTH     = 2;

  typedef enum logic [2:0] {
    OP_RESET    = 3'd0,
    OP_WR_BYTE  = 3'd1,
    OP_RD_BYTE  = 3'd2,
    OP_WR_BIT   = 3'd3,
    OP_RD_BIT   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HOLD  = 4'd5,
    PH_WR_REC   = 4'd6,
    PH_RD_LOW   = 4'd7,
    PH_RD_WAIT  = 4'd8,
    PH_RD_TAIL  = 4'd9
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_RECOVER = 3'd2,
    REG_WRITE_LOW     = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_READ_LOW      = 3'd5,
    REG_READ_WAIT     = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_idx_t;

  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef cfg_word_t [NUM_REGS-1:0] cfg_file_t;

  // Index 0 sits in the lowest slice.
  localparam cfg_file_t CFG_RESET_VALS = {
    10'd50, 10'd5, 10'd5, 10'd60, 10'd10, 10'd500, 10'd70, 10'd500
  };

  // One classified tick as it waits between the front and the sequencer.
  typedef struct packed {
    logic       start;
    op_t        op;
    logic [7:0] wdata;
    logic       bus;
  } tick_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       presence;
  } res_t;

endpackage

// File: src/onewire_bus_master_top.sv
// Top level of the 1-Wire bus master: front end, tick queue, sequencer, result queue.
// Depends on owm_pkg, owm_front, owm_fifo and owm_back.
//
//   channel   direction  handshake          payload
//   in_*      input      push / full        cmd_valid, opcode, write_data, bus_in
//   out_*     output     empty / pop        drive_low, busy_res, done_res, read_data, presence
//   cfg_*     input      cfg_valid/ready    cfg_index, cfg_data
//
// One tick is taken and one result produced per clock while a tick waits and the result
// queue has room; the sequencer's phase/timer update, once per accepted tick, sets that rate.
// A tick's result reaches the result ports through the tick queue, then the result queue.
// Synchronous active-low reset empties both queues, idles the sequencer and loads
// the default timings. A stalled result side fills the queues and then raises full.
module onewire_bus_master_top #(
  parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_cmd_valid,
  input  logic [2:0]                    in_opcode,
  input  logic [7:0]                    in_write_data,
  input  logic                          in_bus_in,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_drive_low,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic [7:0]                    out_read_data,
  output logic                          out_presence,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);
  localparam int TW = $bits(owm_pkg::tick_t);
  localparam int RW = $bits(owm_pkg::res_t);

  owm_pkg::tick_t q_entry, tick_head;
  owm_pkg::res_t  res, res_head;
  logic           q_push, q_full, q_empty, tick_take;
  logic           res_push, res_full;

  assign cfg_ready = 1'b1;

  owm_front u_front (
    .push          (push),
    .full          (full),
    .in_cmd_valid  (in_cmd_valid),
    .in_opcode     (in_opcode),
    .in_write_data (in_write_data),
    .in_bus_in     (in_bus_in),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  owm_fifo #(.WIDTH(TW), .DEPTH(owm_pkg::IN_Q_DEPTH)) u_tick_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_entry),
    .full    (q_full),
    .rd_en   (tick_take),
    .rd_data (tick_head),
    .empty   (q_empty)
  );

  owm_back #(.TIMER_WIDTH(TIMER_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .tick_avail (!q_empty),
    .tick       (tick_head),
    .tick_take  (tick_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  owm_fifo #(.WIDTH(RW), .DEPTH(owm_pkg::OUT_Q_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign out_drive_low = res_head.drive_low;
  assign out_busy_res  = res_head.busy;
  assign out_done_res  = res_head.done;
  assign out_read_data = res_head.read_data;
  assign out_presence  = res_head.presence;
endmodule

// File: src/owm_fifo.sv
// Small synchronous queue used between the front, the sequencer and the output.
// No dependencies beyond its parameters.
module owm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end
endmodule

// File: src/owm_front.sv
// Front end: takes ticks from the input channel and classifies the command.
// Depends on owm_pkg for the tick record and opcode codes.
module owm_front (
  input  logic           push,
  output logic           full,
  input  logic           in_cmd_valid,
  input  logic [2:0]     in_opcode,
  input  logic [7:0]     in_write_data,
  input  logic           in_bus_in,
  input  logic           q_full,
  output logic           q_push,
  output owm_pkg::tick_t q_entry
);
  logic legal_op;

  // Opcodes past read bit start no command and pass on as reset, so the sequencer never sees them.
  assign legal_op = (in_opcode <= 3'(owm_pkg::OP_RD_BIT));

  assign full   = q_full;
  assign q_push = push;

  always_comb begin
    q_entry.start = in_cmd_valid && legal_op;
    q_entry.op    = legal_op ? owm_pkg::op_t'(in_opcode) : owm_pkg::OP_RESET;
    q_entry.wdata = (in_opcode == 3'(owm_pkg::OP_WR_BIT)) ? {7'd0, in_write_data[0]}
                                                          : in_write_data;
    q_entry.bus   = in_bus_in;
  end
endmodule

// File: src/owm_back.sv
// Slot sequencer: runs one tick per transfer and holds the timing registers.
// Depends on owm_pkg for the phase, opcode and record types.
module owm_back #(
  parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [owm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           tick_avail,
  input  owm_pkg::tick_t                 tick,
  output logic                           tick_take,
  input  logic                           res_full,
  output logic                           res_push,
  output owm_pkg::res_t                  res
);
  localparam int LW = (TIMER_WIDTH + 1 > owm_pkg::CFG_W) ? TIMER_WIDTH + 1 : owm_pkg::CFG_W;

  owm_pkg::cfg_file_t      cfg_r;
  owm_pkg::phase_t         phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0]  tick_r, tick_nxt;
  logic [2:0]              bit_r, bit_nxt;
  logic [7:0]              shift_r, shift_nxt;
  owm_pkg::op_t            aop_r, aop_nxt;
  logic [7:0]              rbyte_r, rbyte_nxt;
  logic                    pres_r, pres_nxt;

  logic                    step;
  logic                    fixed_len;
  owm_pkg::reg_idx_t       sel;
  logic [LW-1:0]           len, raw, tc_inc;

  assign step      = tick_avail && !res_full;
  assign tick_take = step;
  assign res_push  = step;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    aop_nxt   = aop_r;
    rbyte_nxt = rbyte_r;
    pres_nxt  = pres_r;
    res.drive_low = 1'b0;
    res.busy      = 1'b0;
    res.done      = 1'b0;
    fixed_len = 1'b0;
    sel       = owm_pkg::REG_RESET_LOW;

    // The accepting tick is already the first tick of the command.
    if (phase_r == owm_pkg::PH_IDLE && tick.start) begin
      aop_nxt   = tick.op;
      bit_nxt   = '0;
      tick_nxt  = '0;
      shift_nxt = (tick.op == owm_pkg::OP_WR_BYTE || tick.op == owm_pkg::OP_WR_BIT)
                  ? tick.wdata : 8'd0;
      unique case (tick.op)
        owm_pkg::OP_RESET:                        phase_nxt = owm_pkg::PH_RST_LOW;
        owm_pkg::OP_WR_BYTE, owm_pkg::OP_WR_BIT:  phase_nxt = owm_pkg::PH_WR_LOW;
        default:                                  phase_nxt = owm_pkg::PH_RD_LOW;
      endcase
    end

    unique case (phase_nxt)
      owm_pkg::PH_RST_LOW:  sel = owm_pkg::REG_RESET_LOW;
      owm_pkg::PH_RST_WAIT: sel = owm_pkg::REG_PRESENCE_WAIT;
      owm_pkg::PH_RST_REC:  sel = owm_pkg::REG_RESET_RECOVER;
      owm_pkg::PH_WR_LOW:   sel = owm_pkg::REG_WRITE_LOW;
      owm_pkg::PH_WR_HOLD:  sel = owm_pkg::REG_WRITE_HOLD;
      owm_pkg::PH_RD_LOW:   sel = owm_pkg::REG_READ_LOW;
      owm_pkg::PH_RD_WAIT:  sel = owm_pkg::REG_READ_WAIT;
      owm_pkg::PH_RD_TAIL:  sel = owm_pkg::REG_READ_TAIL;
      default:              fixed_len = 1'b1;
    endcase

    // A zero register counts as one tick; lengths beyond the timer saturate.
    raw = LW'(cfg_r[sel]);
    if (fixed_len || raw == '0) begin
      len = LW'(1);
    end else if (raw > (LW'(1) << TIMER_WIDTH)) begin
      len = LW'(1) << TIMER_WIDTH;
    end else begin
      len = raw;
    end
    tc_inc = LW'(tick_nxt) + LW'(1);

    if (phase_nxt != owm_pkg::PH_IDLE) begin
      res.busy = 1'b1;
      res.drive_low = (phase_nxt == owm_pkg::PH_RST_LOW) || (phase_nxt == owm_pkg::PH_WR_LOW)
                   || (phase_nxt == owm_pkg::PH_RD_LOW)
                   || (phase_nxt == owm_pkg::PH_WR_HOLD && !shift_nxt[0]);

      if (phase_nxt == owm_pkg::PH_RST_REC && tick_nxt == '0) begin
        pres_nxt = !tick.bus;
      end
      if (phase_nxt == owm_pkg::PH_RD_TAIL && tick_nxt == '0) begin
        shift_nxt = shift_nxt | (8'(tick.bus) << bit_nxt);
      end

      if (tc_inc < len) begin
        tick_nxt = tick_nxt + TIMER_WIDTH'(1);
      end else begin
        tick_nxt = '0;
        unique case (phase_nxt)
          owm_pkg::PH_RST_LOW:  phase_nxt = owm_pkg::PH_RST_WAIT;
          owm_pkg::PH_RST_WAIT: phase_nxt = owm_pkg::PH_RST_REC;
          owm_pkg::PH_WR_LOW:   phase_nxt = owm_pkg::PH_WR_HOLD;
          owm_pkg::PH_WR_HOLD:  phase_nxt = owm_pkg::PH_WR_REC;
          owm_pkg::PH_RD_LOW:   phase_nxt = owm_pkg::PH_RD_WAIT;
          owm_pkg::PH_RD_WAIT:  phase_nxt = owm_pkg::PH_RD_TAIL;
          owm_pkg::PH_WR_REC: begin
            if (aop_nxt == owm_pkg::OP_WR_BIT || bit_nxt == 3'd7) begin
              phase_nxt = owm_pkg::PH_IDLE;
              res.done  = 1'b1;
            end else begin
              bit_nxt   = bit_nxt + 3'd1;
              shift_nxt = shift_nxt >> 1;
              phase_nxt = owm_pkg::PH_WR_LOW;
            end
          end
          owm_pkg::PH_RD_TAIL: begin
            if (aop_nxt == owm_pkg::OP_RD_BIT || bit_nxt == 3'd7) begin
              rbyte_nxt = shift_nxt;
              phase_nxt = owm_pkg::PH_IDLE;
              res.done  = 1'b1;
            end else begin
              bit_nxt   = bit_nxt + 3'd1;
              phase_nxt = owm_pkg::PH_RD_LOW;
            end
          end
          default: begin
            phase_nxt = owm_pkg::PH_IDLE;
            res.done  = 1'b1;
          end
        endcase
      end
    end

    res.read_data = rbyte_nxt;
    res.presence  = pres_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owm_pkg::PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      aop_r   <= owm_pkg::OP_RESET;
      rbyte_r <= '0;
      pres_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      aop_r   <= aop_nxt;
      rbyte_r <= rbyte_nxt;
      pres_r  <= pres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= owm_pkg::CFG_RESET_VALS;
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end
endmodule

// File: src/owm_checker.sv
// Port-level checks of the 1-Wire bus master, bound to the top level.
// Depends on assert_macros.svh and onewire_bus_master_top.
`include "assert_macros.svh"

module owm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic       out_drive_low,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_read_data
);
  // The line is only pulled while a command runs.
  `OWM_ASSERT_IMPL(a_drive_busy, clk, rst_n, !empty && out_drive_low, out_busy_res)
  // A finishing tick still belongs to its command.
  `OWM_ASSERT_IMPL(a_done_busy, clk, rst_n, !empty && out_done_res, out_busy_res)
  // A waiting result holds until its transfer.
  `OWM_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop,
                   !empty && $stable(out_read_data) && $stable(out_done_res))
endmodule

bind onewire_bus_master_top owm_checker u_owm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .empty         (empty),
  .pop           (pop),
  .out_drive_low (out_drive_low),
  .out_busy_res  (out_busy_res),
  .out_done_res  (out_done_res),
  .out_read_data (out_read_data)
);
